// File: src/ctse_pkg.sv
// Shared types, codes and helpers for the clock time-set editor.
package ctse_pkg;

	localparam logic [3:0] KEY_INC    = 4'd1;
	localparam logic [3:0] KEY_NEXT   = 4'd2;
	localparam logic [3:0] KEY_SAVE   = 4'd11;
	localparam logic [3:0] KEY_CANCEL = 4'd12;

	localparam logic [1:0] FIELD_HOUR = 2'd0;
	localparam logic [1:0] FIELD_MIN  = 2'd1;
	localparam logic [1:0] FIELD_SEC  = 2'd2;

	localparam logic [1:0] ACT_DRAW   = 2'd0;
	localparam logic [1:0] ACT_BLANK  = 2'd1;
	localparam logic [1:0] ACT_NONE   = 2'd2;
	localparam logic [1:0] ACT_EXITED = 2'd3;

	localparam logic [5:0] HOUR_MAX   = 6'd23;
	localparam logic [7:0] MINSEC_MAX = 8'd59;

	localparam logic [9:0] SHOW_RESET   = 10'd500;
	localparam logic [9:0] PERIOD_RESET = 10'd1000;

	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 56;

	typedef struct packed {
		logic       session_start;
		logic [7:0] rtc_hour_reg;
		logic [7:0] rtc_minute_reg;
		logic [7:0] rtc_second_reg;
		logic [3:0] key_code;
	} item_t;

	typedef struct packed {
		logic [5:0] hours;
		logic [7:0] minutes;
		logic [7:0] seconds;
		logic [1:0] field;
		logic [9:0] blink;
	} state_t;

	typedef struct packed {
		logic [9:0] show;
		logic [9:0] period;
	} cfg_t;

	typedef struct packed {
		logic [5:0] hours_value;
		logic [7:0] minutes_value;
		logic [7:0] seconds_value;
		logic [1:0] selected_field;
		logic [1:0] display_action;
		logic       save_strobe;
		logic       exit_strobe;
		logic [7:0] hours_bcd_out;
		logic [7:0] minutes_bcd_out;
		logic [7:0] seconds_bcd_out;
	} result_t;

	// Binary to two BCD nibbles; divide by 10 as multiply by 205, shift 11 (exact below 1029)
	function automatic logic [7:0] to_bcd(input logic [7:0] v);
		logic [15:0] p;
		logic [4:0]  q;
		logic [7:0]  tens_x10;
		logic [7:0]  r;
		p        = {8'd0, v} * 16'd205;
		q        = p[15:11];
		tens_x10 = {q[4:0], 3'b000} + {2'b00, q[4:0], 1'b0};
		r        = v - tens_x10;
		return {q[3:0], r[3:0]};
	endfunction

endpackage

// File: src/ctse_step.sv
// Next-state and result logic for one editor step.
module ctse_step (
	input  ctse_pkg::item_t   item,
	input  ctse_pkg::state_t  cur,
	input  ctse_pkg::cfg_t    cfg,
	output ctse_pkg::state_t  nxt,
	output ctse_pkg::result_t res
);
	import ctse_pkg::*;

	logic [1:0]  h_tens;
	logic [5:0]  ld_hours;
	logic [7:0]  ld_minutes;
	logic [7:0]  ld_seconds;
	logic [5:0]  h_cur;
	logic [7:0]  m_cur;
	logic [7:0]  s_cur;
	logic [6:0]  h_inc;
	logic [8:0]  m_inc;
	logic [8:0]  s_inc;
	logic [10:0] blink_inc;
	logic        quit;
	logic        save;

	always_comb begin
		h_tens = item.rtc_hour_reg[6] ? {1'b0, item.rtc_hour_reg[4]} : item.rtc_hour_reg[5:4];
		ld_hours = {1'b0, h_tens, 3'b000} + {3'b000, h_tens, 1'b0}
			+ {2'b00, item.rtc_hour_reg[3:0]};
		ld_minutes = {1'b0, item.rtc_minute_reg[7:4], 3'b000}
			+ {3'b000, item.rtc_minute_reg[7:4], 1'b0} + {4'b0000, item.rtc_minute_reg[3:0]};
		ld_seconds = {1'b0, item.rtc_second_reg[7:4], 3'b000}
			+ {3'b000, item.rtc_second_reg[7:4], 1'b0} + {4'b0000, item.rtc_second_reg[3:0]};

		h_cur = item.session_start ? ld_hours   : cur.hours;
		m_cur = item.session_start ? ld_minutes : cur.minutes;
		s_cur = item.session_start ? ld_seconds : cur.seconds;

		h_inc     = {1'b0, h_cur} + 7'd1;
		m_inc     = {1'b0, m_cur} + 9'd1;
		s_inc     = {1'b0, s_cur} + 9'd1;
		blink_inc = {1'b0, cur.blink} + 11'd1;

		quit = (item.key_code == KEY_SAVE) || (item.key_code == KEY_CANCEL);
		save = (item.key_code == KEY_SAVE);

		nxt.hours   = h_cur;
		nxt.minutes = m_cur;
		nxt.seconds = s_cur;
		nxt.field   = cur.field;
		nxt.blink   = cur.blink;
		res.display_action = ACT_EXITED;

		if (!quit) begin
			if (item.key_code == KEY_INC) begin
				case (cur.field)
					FIELD_HOUR: nxt.hours   = (h_inc > {1'b0, HOUR_MAX}) ? 6'd0 : h_inc[5:0];
					FIELD_MIN:  nxt.minutes = (m_inc > {1'b0, MINSEC_MAX}) ? 8'd0 : m_inc[7:0];
					FIELD_SEC:  nxt.seconds = (s_inc > {1'b0, MINSEC_MAX}) ? 8'd0 : s_inc[7:0];
					default:    ;
				endcase
			end else if (item.key_code == KEY_NEXT) begin
				nxt.field = (cur.field >= FIELD_SEC) ? FIELD_HOUR : cur.field + 2'd1;
			end

			if (cur.blink < cfg.show) begin
				nxt.blink = blink_inc[9:0];
				res.display_action = ACT_DRAW;
			end else if (blink_inc < {1'b0, cfg.period}) begin
				nxt.blink = blink_inc[9:0];
				res.display_action = ACT_BLANK;
			end else begin
				nxt.blink = 10'd0;
				res.display_action = ACT_NONE;
			end
		end

		res.hours_value     = nxt.hours;
		res.minutes_value   = nxt.minutes;
		res.seconds_value   = nxt.seconds;
		res.selected_field  = nxt.field;
		res.save_strobe     = save;
		res.exit_strobe     = quit;
		res.hours_bcd_out   = save ? to_bcd({2'b00, h_cur}) : 8'd0;
		res.minutes_bcd_out = save ? to_bcd(m_cur) : 8'd0;
		res.seconds_bcd_out = save ? to_bcd(s_cur) : 8'd0;
	end

endmodule

// File: src/clock_time_set_editor.sv
// Top level of the clock time-set editor: stream channels, APB registers, edit state.
//
// Channel   Dir  Payload
// s_*       in   tdata: hour reg, minute reg, second reg, key code; tuser: session start
// m_*       out  tdata: values, field, action, BCD outputs; tuser: save, exit strobes
// apb       in   blink_show_steps at 0x0, blink_period_steps at 0x4
//
// One transfer in gives one transfer out, through the input register and then
// the result register; one item per cycle sustained while m_tready is high.
// The edit state updates as an item leaves the input register. arst_n clears
// state, valids and the registers to 500/1000. A stalled m_tready holds the
// result and fills the input register before s_tready drops.
module clock_time_set_editor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [7:0] rtc_hour_reg, [15:8] rtc_minute_reg, [23:16] rtc_second_reg, [27:24] key_code
	input  logic [ctse_pkg::IN_DATA_W-1:0]       s_tdata,
	// [0] session_start
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [5:0] hours_value, [13:6] minutes_value, [21:14] seconds_value,
	// [23:22] selected_field, [25:24] display_action, [33:26] hours_bcd_out,
	// [41:34] minutes_bcd_out, [49:42] seconds_bcd_out
	output logic [ctse_pkg::OUT_DATA_W-1:0]      m_tdata,
	// [0] save_strobe, [1] exit_strobe
	output logic [1:0]                           m_tuser,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [2:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import ctse_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    adv_s1;
	logic    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? {22'd0, cfg_q.period} : {22'd0, cfg_q.show};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.show   <= SHOW_RESET;
			cfg_q.period <= PERIOD_RESET;
		end else if (cfg_wr) begin
			if (paddr[2]) cfg_q.period <= pwdata[9:0];
			else          cfg_q.show   <= pwdata[9:0];
		end
	end

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.session_start  <= s_tuser;
			item_s1.rtc_hour_reg   <= s_tdata[7:0];
			item_s1.rtc_minute_reg <= s_tdata[15:8];
			item_s1.rtc_second_reg <= s_tdata[23:16];
			item_s1.key_code       <= s_tdata[27:24];
		end
	end

	ctse_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_nxt;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.seconds_bcd_out, res_s2.minutes_bcd_out,
		res_s2.hours_bcd_out, res_s2.display_action, res_s2.selected_field,
		res_s2.seconds_value, res_s2.minutes_value, res_s2.hours_value};
	assign m_tuser  = {res_s2.exit_strobe, res_s2.save_strobe};

endmodule
